@@ sv/matrix4_vector_transform_assert.svh @@
// Assertion macros for the matrix4_vector_transform RTL.
// Used by files that carry concurrent checks; needs no other file.
`ifndef MATRIX4_VECTOR_TRANSFORM_ASSERT_SVH
`define MATRIX4_VECTOR_TRANSFORM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define M4VT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define M4VT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/m4vt_pkg.sv @@
// Shared types and constants for the 4x4 matrix-vector transform.
// No dependencies; imported by every module of the block.
package m4vt_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int PORT_W    = 32;                 // width of value fields on ports
  localparam int PROD_W    = 2 * WORD_BITS;      // full product
  localparam int PAIR_W    = PROD_W + 1;         // sum of two products
  localparam int SUM_W     = PROD_W + 2;         // sum of four products
  localparam int DIM       = 4;
  localparam int IDX_W     = 2;                  // row / column index width

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef word_t [DIM-1:0]             row_t;
  typedef row_t  [DIM-1:0]             mat_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } opcode_t;

  // Per-stage advance enables, shared by all lanes
  typedef struct packed {
    logic en1;     // product stage
    logic en2;     // pair-sum stage
    logic en3;     // total-sum stage
    logic en_out;  // saturate / output stage
  } pipe_ctl_t;

endpackage

@@ sv/m4vt_mat_store.sv @@
// Matrix store: 16 words in flip-flops, row-major, reset to zero.
// Depends on m4vt_pkg.
module m4vt_mat_store
  import m4vt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_row,
  input  logic [IDX_W-1:0] wr_col,
  input  word_t            wr_data,
  output mat_t             mat
);

  mat_t mat_r;

  // One entry written per load transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= '0;
    end else if (wr_en) begin
      mat_r[wr_row][wr_col] <= wr_data;
    end
  end

  assign mat = mat_r;

endmodule

@@ sv/m4vt_dot_lane.sv @@
// One row of the transform: 4 multiplies, two-level add tree, shift and saturate.
// Depends on m4vt_pkg; stage enables come from the top level.
module m4vt_dot_lane
  import m4vt_pkg::*;
(
  input  logic                     clk,
  input  pipe_ctl_t                ctl,
  input  row_t                     row_i,
  input  row_t                     vec_i,
  output logic signed [PORT_W-1:0] res,
  output logic                     ovf
);

  logic signed [PROD_W-1:0] prod_r [DIM];
  logic signed [PAIR_W-1:0] pair_r [2];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [PORT_W-1:0] res_r;
  logic                     ovf_r;

  logic signed [SUM_W-1:0]  shifted;
  logic                     sat;
  word_t                    sat_word;

  // Stage 1: full products
  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      for (int k = 0; k < DIM; k++) begin
        prod_r[k] <= $signed(row_i[k]) * $signed(vec_i[k]);
      end
    end
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      pair_r[0] <= {prod_r[0][PROD_W-1], prod_r[0]} + {prod_r[1][PROD_W-1], prod_r[1]};
      pair_r[1] <= {prod_r[2][PROD_W-1], prod_r[2]} + {prod_r[3][PROD_W-1], prod_r[3]};
    end
  end

  // Stage 3: exact four-term sum
  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      sum_r <= {pair_r[0][PAIR_W-1], pair_r[0]} + {pair_r[1][PAIR_W-1], pair_r[1]};
    end
  end

  // Floor shift, then saturate when the high bits are not a sign extension
  always_comb begin
    shifted = sum_r >>> FRAC_BITS;
    sat     = (shifted[SUM_W-1:WORD_BITS-1] != '0) &&
              (shifted[SUM_W-1:WORD_BITS-1] != '1);
    if (!sat) begin
      sat_word = shifted[WORD_BITS-1:0];
    end else if (shifted[SUM_W-1]) begin
      sat_word = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      sat_word = {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  end

  // Output stage, sign-extended to the port width
  always_ff @(posedge clk) begin
    if (ctl.en_out) begin
      res_r <= PORT_W'(sat_word);
      ovf_r <= sat;
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;

endmodule

@@ sv/matrix4_vector_transform.sv @@
// Top level of the 4x4 matrix-vector transform, Q16.16 with saturation.
// Depends on m4vt_pkg, m4vt_mat_store, m4vt_dot_lane and the assertion header.
//
//   channel   direction   handshake               payload
//   in_       input       in_valid / in_stall     opcode, entry row/col/value, vec x..w
//   out_      output      out_valid / out_stall   res x..w, overflow
//
// One item per cycle while out_stall lets the pipe drain; a transform result passes
// through the product, pair sum, total sum and saturate/output registers after its transfer.
// A load writes the matrix at its transfer edge and gives no result; a
// transform transferred in the next cycle already sees the new entry.
// Each stage advances when the stage after it is empty or moving, so bubbles
// collapse and input is taken while a finished result waits on out_stall.
// Synchronous active-low reset clears the stage valids and the matrix.
`include "matrix4_vector_transform_assert.svh"

module matrix4_vector_transform
  import m4vt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic [IDX_W-1:0]         in_entry_row,
  input  logic [IDX_W-1:0]         in_entry_col,
  input  logic signed [PORT_W-1:0] in_entry_value,
  input  logic signed [PORT_W-1:0] in_vec_x,
  input  logic signed [PORT_W-1:0] in_vec_y,
  input  logic signed [PORT_W-1:0] in_vec_z,
  input  logic signed [PORT_W-1:0] in_vec_w,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [PORT_W-1:0] out_res_x,
  output logic signed [PORT_W-1:0] out_res_y,
  output logic signed [PORT_W-1:0] out_res_z,
  output logic signed [PORT_W-1:0] out_res_w,
  output logic                     out_overflow
);

  logic              v1_r, v2_r, v3_r, vo_r;
  logic              v1_nxt, v2_nxt, v3_nxt, vo_nxt;
  pipe_ctl_t         ctl;
  logic              in_xfer;
  logic              is_xform;
  row_t              vec;
  mat_t              mat;
  logic [DIM-1:0]    lane_ovf;
  logic signed [PORT_W-1:0] lane_res [DIM];

  // Stage enables: a stage moves when the next one is empty or moving
  always_comb begin
    ctl.en_out = !vo_r || !out_stall;
    ctl.en3    = !v3_r || ctl.en_out;
    ctl.en2    = !v2_r || ctl.en3;
    ctl.en1    = !v1_r || ctl.en2;
  end

  assign in_stall = !ctl.en1;
  assign in_xfer  = in_valid && !in_stall;
  assign is_xform = (in_opcode == OP_XFORM);

  // Valid bits travel with the data
  always_comb begin
    v1_nxt = ctl.en1    ? (in_xfer && is_xform) : v1_r;
    v2_nxt = ctl.en2    ? v1_r : v2_r;
    v3_nxt = ctl.en3    ? v2_r : v3_r;
    vo_nxt = ctl.en_out ? v3_r : vo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      vo_r <= vo_nxt;
    end
  end

  // Narrow the vector to the working word
  assign vec[0] = in_vec_x[WORD_BITS-1:0];
  assign vec[1] = in_vec_y[WORD_BITS-1:0];
  assign vec[2] = in_vec_z[WORD_BITS-1:0];
  assign vec[3] = in_vec_w[WORD_BITS-1:0];

  m4vt_mat_store u_mat (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_xfer && !is_xform),
    .wr_row  (in_entry_row),
    .wr_col  (in_entry_col),
    .wr_data (in_entry_value[WORD_BITS-1:0]),
    .mat     (mat)
  );

  // One lane per matrix row
  for (genvar r = 0; r < DIM; r++) begin : g_lane
    m4vt_dot_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .row_i (mat[r]),
      .vec_i (vec),
      .res   (lane_res[r]),
      .ovf   (lane_ovf[r])
    );
  end

  assign out_valid    = vo_r;
  assign out_res_x    = lane_res[0];
  assign out_res_y    = lane_res[1];
  assign out_res_z    = lane_res[2];
  assign out_res_w    = lane_res[3];
  assign out_overflow = |lane_ovf;

  // Checks
  `M4VT_ASSERT_NEXT(a_load_no_entry, clk, rst_n, in_xfer && !is_xform, !v1_r, "load entered pipe")
  `M4VT_ASSERT_NOW(a_empty_out_ready, clk, rst_n, !vo_r, !in_stall, "stall with empty output")
  `M4VT_ASSERT_NEXT(a_s3_to_out, clk, rst_n, v3_r && ctl.en_out, out_valid, "result lost")
  `M4VT_ASSERT_NEXT(a_out_drain, clk, rst_n, vo_r && !out_stall && !v3_r, !out_valid,
                    "result repeated")

endmodule

@@ tb/m4vt_checker.sv @@
// Scoreboard for matrix4_vector_transform: keeps its own copy of the matrix,
// predicts every transform result and checks the out_ channel in order.
// Depends on m4vt_pkg for the widths and the opcode encoding.
module m4vt_checker
  import m4vt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_opcode,
  input  logic [IDX_W-1:0]         in_entry_row,
  input  logic [IDX_W-1:0]         in_entry_col,
  input  logic signed [PORT_W-1:0] in_entry_value,
  input  logic signed [PORT_W-1:0] in_vec_x,
  input  logic signed [PORT_W-1:0] in_vec_y,
  input  logic signed [PORT_W-1:0] in_vec_z,
  input  logic signed [PORT_W-1:0] in_vec_w,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [PORT_W-1:0] out_res_x,
  input  logic signed [PORT_W-1:0] out_res_y,
  input  logic signed [PORT_W-1:0] out_res_z,
  input  logic signed [PORT_W-1:0] out_res_w,
  input  logic                     out_overflow,
  output int                       mismatches,
  output int                       pending,
  output int                       results_checked,
  output int                       results_saturated
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [PORT_W-1:0] x;
    logic signed [PORT_W-1:0] y;
    logic signed [PORT_W-1:0] z;
    logic signed [PORT_W-1:0] w;
    logic                     ovf;
  } xform_result_t;

  mat_t          matrix_copy;
  xform_result_t expected_results[$];
  int            n_bad;
  int            n_seen;
  int            n_sat;

  // Port value -> fixed-point word (low WORD_BITS bits, sign-extended)
  function automatic word_t to_word(input logic [PORT_W-1:0] raw);
    return word_t'(raw[WORD_BITS-1:0]);
  endfunction

  // Four exact row sums, floor shift by FRAC_BITS, saturate to the word range
  function automatic xform_result_t transform_vector(input mat_t m, input row_t vec);
    xform_result_t               res;
    logic signed [SUM_W-1:0]     acc;
    logic signed [SUM_W-1:0]     a;
    logic signed [SUM_W-1:0]     b;
    logic signed [SUM_W-1:0]     hi;
    logic signed [SUM_W-1:0]     lo;
    logic signed [WORD_BITS-1:0] narrow;
    logic signed [PORT_W-1:0]    comp [DIM];
    res = '0;
    hi  = $signed({1'b0, {(WORD_BITS-1){1'b1}}});
    lo  = -hi - 1;
    for (int r = 0; r < DIM; r++) begin
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
        a   = $signed(m[r][k]);
        b   = $signed(vec[k]);
        acc = acc + a * b;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > hi) begin
        acc     = hi;
        res.ovf = 1'b1;
      end else if (acc < lo) begin
        acc     = lo;
        res.ovf = 1'b1;
      end
      narrow  = acc[WORD_BITS-1:0];
      comp[r] = narrow;
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    res.w = comp[3];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [PORT_W-1:0] want,
                             input logic [PORT_W-1:0] seen);
    if (seen !== want) begin
      n_bad++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
    end
  endtask

  // Result side is checked before the input side; a transform accepted at
  // this edge cannot have its result out at the same edge.
  always @(posedge clk) begin : scoreboard
    xform_result_t want;
    row_t          vec;
    if (!rst_n) begin
      matrix_copy = '0;
      expected_results.delete();
      n_bad  = 0;
      n_seen = 0;
      n_sat  = 0;
    end else begin
      // result transfer
      if (out_valid && !out_stall) begin
        n_seen++;
        if (out_overflow === 1'b1) n_sat++;
        if (expected_results.size() == 0) begin
          n_bad++;
          $display("%0t: unexpected result, expected none, actual %h %h %h %h ovf=%b",
                   $time, out_res_x, out_res_y, out_res_z, out_res_w, out_overflow);
        end else begin
          want = expected_results.pop_front();
          check_field("res_x", want.x, out_res_x);
          check_field("res_y", want.y, out_res_y);
          check_field("res_z", want.z, out_res_z);
          check_field("res_w", want.w, out_res_w);
          check_field("overflow", PORT_W'(want.ovf), PORT_W'(out_overflow));
        end
      end
      // input transfer: loads update the copy, transforms queue a prediction
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_LOAD) begin
          matrix_copy[in_entry_row][in_entry_col] = to_word(in_entry_value);
        end else begin
          vec[0] = to_word(in_vec_x);
          vec[1] = to_word(in_vec_y);
          vec[2] = to_word(in_vec_z);
          vec[3] = to_word(in_vec_w);
          expected_results.push_back(transform_vector(matrix_copy, vec));
        end
      end
    end
    mismatches        <= n_bad;
    pending           <= expected_results.size();
    results_checked   <= n_seen;
    results_saturated <= n_sat;
  end

endmodule

@@ tb/matrix4_vector_transform_tb.sv @@
// Testbench top for matrix4_vector_transform: clock, reset, stimulus, output
// stalls and the verdict. Depends on m4vt_pkg, the RTL and m4vt_checker.
module matrix4_vector_transform_tb
  import m4vt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PORT_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [PORT_W-1:0] Q_MIN     = 32'h8000_0000;
  localparam logic [PORT_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [PORT_W-1:0] Q_LSB     = 32'h0000_0001;
  localparam logic [PORT_W-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;
  localparam logic [PORT_W-1:0] Q_ZERO    = 32'h0000_0000;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_stall;
  logic                     in_opcode      = 1'b0;
  logic [IDX_W-1:0]         in_entry_row   = '0;
  logic [IDX_W-1:0]         in_entry_col   = '0;
  logic signed [PORT_W-1:0] in_entry_value = '0;
  logic signed [PORT_W-1:0] in_vec_x       = '0;
  logic signed [PORT_W-1:0] in_vec_y       = '0;
  logic signed [PORT_W-1:0] in_vec_z       = '0;
  logic signed [PORT_W-1:0] in_vec_w       = '0;
  logic                     out_valid;
  logic                     out_stall      = 1'b0;
  logic signed [PORT_W-1:0] out_res_x;
  logic signed [PORT_W-1:0] out_res_y;
  logic signed [PORT_W-1:0] out_res_z;
  logic signed [PORT_W-1:0] out_res_w;
  logic                     out_overflow;

  int mismatches;
  int pending;
  int results_checked;
  int results_saturated;

  int idle_pct        = 0;
  int stall_pct       = 0;
  int holds_requested = 0;
  int holds_served    = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;
  int n_loads         = 0;
  int n_xforms        = 0;

  matrix4_vector_transform u_top (.*);
  m4vt_checker u_checker (.*);

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_requested) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly moderate Q16.16 values that stay in range, some extremes and raw words
  function automatic logic [PORT_W-1:0] rand_fixed(input int wide_pct);
    if ($urandom_range(0, 99) < wide_pct) begin
      case ($urandom_range(0, 3))
        0:       return Q_MAX;
        1:       return Q_MIN;
        default: return $urandom();
      endcase
    end
    if ($urandom_range(0, 9) == 0) return PORT_W'(int'($urandom_range(0, 4)) - 2);
    return PORT_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
  endfunction

  // One input transfer, after a random idle gap
  task automatic send_item(input opcode_t op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [PORT_W-1:0] value,
                           input logic [PORT_W-1:0] vx, input logic [PORT_W-1:0] vy,
                           input logic [PORT_W-1:0] vz, input logic [PORT_W-1:0] vw);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_entry_row   <= row;
    in_entry_col   <= col;
    in_entry_value <= value;
    in_vec_x       <= vx;
    in_vec_y       <= vy;
    in_vec_z       <= vz;
    in_vec_w       <= vw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_LOAD) n_loads++;
    else n_xforms++;
  endtask

  // Loads carry junk vector fields, transforms junk entry fields
  task automatic load_entry(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                            input logic [PORT_W-1:0] value);
    send_item(OP_LOAD, row, col, value, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic transform(input logic [PORT_W-1:0] vx, input logic [PORT_W-1:0] vy,
                           input logic [PORT_W-1:0] vz, input logic [PORT_W-1:0] vw);
    send_item(OP_XFORM, IDX_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
              $urandom(), vx, vy, vz, vw);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 40)
        load_entry(IDX_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
                   rand_fixed(10));
      else
        transform(rand_fixed(25), rand_fixed(25), rand_fixed(25), rand_fixed(25));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero matrix straight out of reset
    transform(Q_MIN, Q_MAX, Q_NEG_LSB, Q_LSB);
    // identity passes the vector through unchanged
    for (int i = 0; i < DIM; i++) load_entry(IDX_W'(i), IDX_W'(i), Q_ONE);
    transform(32'h0001_8000, 32'hFFFD_C000, Q_MAX, Q_MIN);
    // tiny negative product rounds toward minus infinity
    load_entry(2'd0, 2'd1, Q_NEG_LSB);
    transform(Q_ZERO, Q_LSB, Q_ZERO, Q_ZERO);
    // extreme diagonal: saturation in both directions
    load_entry(2'd0, 2'd0, Q_MAX);
    load_entry(2'd1, 2'd1, Q_MIN);
    load_entry(2'd2, 2'd2, Q_MIN);
    load_entry(2'd3, 2'd3, Q_MAX);
    transform(Q_MAX, Q_MAX, Q_MIN, Q_MIN);
    transform(Q_LSB, Q_LSB, Q_LSB, Q_LSB);
    transform(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
    // huge products that cancel inside the row sum
    load_entry(2'd3, 2'd0, Q_MIN);
    transform(Q_MIN, Q_ZERO, Q_ZERO, Q_MIN);

    // Random phases: sender idle / receiver stall percentages
    run_random(250);
    idle_pct  = 80;
    run_random(200);
    idle_pct  = 0;
    stall_pct = 80;
    run_random(200);
    idle_pct  = 17;
    stall_pct = 17;
    run_random(200);
    // long output hold-off while the sender keeps pushing
    idle_pct  = 0;
    stall_pct = 0;
    holds_requested++;
    run_random(100);

    // Drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d loads and %0d transforms transferred, %0d results checked",
             n_loads, n_xforms, results_checked);
    $display("Summary: %0d saturated; idle/stall 0/0, 80/0, 0/80, 17/17 and a %0d-cycle hold",
             results_saturated, HOLD_CYCLES);
    if (mismatches == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
